/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the date/time setter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define DTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that stays live through reset.
`define DTS_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/dts_pkg.sv */
// Types, constants and calendar helpers for the date/time setter.
package dts_pkg;

    // Request codes; code 7 is unused and does nothing.
    typedef enum logic [2:0] {
        REQ_LEFT   = 3'd0,
        REQ_CENTER = 3'd1,
        REQ_RIGHT  = 3'd2,
        REQ_UP     = 3'd3,
        REQ_DOWN   = 3'd4,
        REQ_TICK   = 3'd5,
        REQ_LOAD   = 3'd6
    } t_req;

    // Cursor positions.
    typedef enum logic [2:0] {
        FLD_HOUR   = 3'd0,
        FLD_MINUTE = 3'd1,
        FLD_SECOND = 3'd2,
        FLD_DAY    = 3'd3,
        FLD_MONTH  = 3'd4,
        FLD_YEAR   = 3'd5
    } t_field;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_time;

    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  DAY_MIN   = 5'd1;
    localparam logic [4:0]  DAY_MAX   = 5'd31;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [11:0] YEAR_MIN  = 12'd1900;
    localparam logic [11:0] YEAR_MAX  = 12'd2100;
    localparam logic [11:0] YEAR_RST  = 12'd2000;

    localparam t_time TIME_RST = '{
        hour: 5'd0, minute: 6'd0, second: 6'd0,
        day: 5'd1, month: 4'd1, year: YEAR_RST
    };

    // Days in month. Year must already be in 1900..2100: inside that span
    // the only century years are 1900 and 2100 (not leap) and 2000 (leap).
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic leap;
        logic [4:0] len;
        leap = (y[1:0] == 2'b00) && (y != YEAR_MIN) && (y != YEAR_MAX);
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/dts_clamp.sv */
// Range clamp of a raw time to a legal calendar time.
module dts_clamp (
    input  dts_pkg::t_time i_raw,
    output dts_pkg::t_time o_time
);

    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_mlen;

    always_comb begin
        if (i_raw.year < dts_pkg::YEAR_MIN) begin
            w_year = dts_pkg::YEAR_MIN;
        end else if (i_raw.year > dts_pkg::YEAR_MAX) begin
            w_year = dts_pkg::YEAR_MAX;
        end else begin
            w_year = i_raw.year;
        end

        if (i_raw.month < dts_pkg::MONTH_MIN) begin
            w_month = dts_pkg::MONTH_MIN;
        end else if (i_raw.month > dts_pkg::MONTH_MAX) begin
            w_month = dts_pkg::MONTH_MAX;
        end else begin
            w_month = i_raw.month;
        end

        // day depends on the already clamped month and year
        w_mlen = dts_pkg::month_len(w_month, w_year);

        o_time.year  = w_year;
        o_time.month = w_month;
        if (i_raw.day < dts_pkg::DAY_MIN) begin
            o_time.day = dts_pkg::DAY_MIN;
        end else if (i_raw.day > w_mlen) begin
            o_time.day = w_mlen;
        end else begin
            o_time.day = i_raw.day;
        end
        o_time.hour   = (i_raw.hour > dts_pkg::HOUR_MAX) ? dts_pkg::HOUR_MAX : i_raw.hour;
        o_time.minute = (i_raw.minute > dts_pkg::MIN_MAX) ? dts_pkg::MIN_MAX : i_raw.minute;
        o_time.second = (i_raw.second > dts_pkg::MIN_MAX) ? dts_pkg::MIN_MAX : i_raw.second;
    end

endmodule

/* hw/rtl/date_time_setter.sv */
// Date/time setter top level: button/knob editor for a calendar time.
// Each accepted word is one user event (left/center/right click, knob up or
// down, tick, or load of a full time) and gives exactly one result word that
// shows the time, edit flag and cursor after that event, plus a commit flag
// that is set only for a center click that ends an edit. Words pass the
// input and then the result register; one word is taken every cycle unless
// the output stalls, as the state update is a single pass of step-and-clamp
// logic between the two registers. After reset the time is 00:00:00 on
// 2000-01-01, not editing, cursor on the hour. Years saturate at 1900 and
// 2100, the day is held within the month length (Gregorian leap years).
`include "assert_macros.svh"

module date_time_setter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event word in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [11:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    input  logic [4:0]  i_load_hour,
    input  logic [5:0]  i_load_minute,
    input  logic [5:0]  i_load_second,
    // result word out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [11:0] o_year_out,
    output logic        o_editing,
    output logic [2:0]  o_cursor,
    output logic        o_commit
);

    // input register
    logic                r_in_valid;
    logic [2:0]          r_req;
    dts_pkg::t_time      r_load;

    // editor state
    dts_pkg::t_time      r_time;
    logic                r_edit;
    dts_pkg::t_field     r_cursor;

    // result register
    logic                r_out_valid;
    dts_pkg::t_time      r_out_time;
    logic                r_out_edit;
    dts_pkg::t_field     r_out_cursor;
    logic                r_out_commit;

    // next state
    dts_pkg::t_time      w_raw;
    dts_pkg::t_time      n_time;
    logic                n_edit;
    dts_pkg::t_field     n_cursor;
    logic                n_commit;

    logic                w_up;
    logic                w_out_ready;
    logic                w_move;
    logic                w_accept;

    // Handshake: the result register frees when empty or being taken; the
    // input register hands its word on whenever the result register frees.
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_move      = r_in_valid && w_out_ready;
    assign o_stall     = r_in_valid && !w_out_ready;
    assign w_accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req         <= i_req_type;
            r_load.year   <= i_load_year;
            r_load.month  <= i_load_month;
            r_load.day    <= i_load_day;
            r_load.hour   <= i_load_hour;
            r_load.minute <= i_load_minute;
            r_load.second <= i_load_second;
        end
    end

    // Step logic. Stored fields are always legal, so a knob step only needs
    // saturation at the field's own bounds; the day is then re-clamped to
    // the month length by the clamp unit, which also covers month and year
    // steps that shorten the month. On idle events the clamp sees the
    // current (legal) time and passes it unchanged.
    assign w_up = (r_req == dts_pkg::REQ_UP);

    always_comb begin
        w_raw    = r_time;
        n_edit   = r_edit;
        n_cursor = r_cursor;
        n_commit = 1'b0;
        case (r_req)
            dts_pkg::REQ_LEFT: begin
                if (!r_edit) begin
                    n_edit = 1'b1;              // first click only enters editing
                end else if (r_cursor != dts_pkg::FLD_HOUR) begin
                    n_cursor = dts_pkg::t_field'(r_cursor - 3'd1);
                end
            end
            dts_pkg::REQ_RIGHT: begin
                if (!r_edit) begin
                    n_edit = 1'b1;
                end else if (r_cursor != dts_pkg::FLD_YEAR) begin
                    n_cursor = dts_pkg::t_field'(r_cursor + 3'd1);
                end
            end
            dts_pkg::REQ_CENTER: begin
                if (r_edit) begin
                    n_commit = 1'b1;
                    n_edit   = 1'b0;
                end
            end
            dts_pkg::REQ_UP, dts_pkg::REQ_DOWN: begin
                if (r_edit) begin
                    case (r_cursor)
                        dts_pkg::FLD_HOUR: begin
                            if (w_up) begin
                                if (r_time.hour != dts_pkg::HOUR_MAX) begin
                                    w_raw.hour = r_time.hour + 5'd1;
                                end
                            end else if (r_time.hour != 5'd0) begin
                                w_raw.hour = r_time.hour - 5'd1;
                            end
                        end
                        dts_pkg::FLD_MINUTE: begin
                            if (w_up) begin
                                if (r_time.minute != dts_pkg::MIN_MAX) begin
                                    w_raw.minute = r_time.minute + 6'd1;
                                end
                            end else if (r_time.minute != 6'd0) begin
                                w_raw.minute = r_time.minute - 6'd1;
                            end
                        end
                        dts_pkg::FLD_SECOND: begin
                            if (w_up) begin
                                if (r_time.second != dts_pkg::MIN_MAX) begin
                                    w_raw.second = r_time.second + 6'd1;
                                end
                            end else if (r_time.second != 6'd0) begin
                                w_raw.second = r_time.second - 6'd1;
                            end
                        end
                        dts_pkg::FLD_DAY: begin
                            if (w_up) begin
                                if (r_time.day != dts_pkg::DAY_MAX) begin
                                    w_raw.day = r_time.day + 5'd1;
                                end
                            end else if (r_time.day != dts_pkg::DAY_MIN) begin
                                w_raw.day = r_time.day - 5'd1;
                            end
                        end
                        dts_pkg::FLD_MONTH: begin
                            if (w_up) begin
                                if (r_time.month != dts_pkg::MONTH_MAX) begin
                                    w_raw.month = r_time.month + 4'd1;
                                end
                            end else if (r_time.month != dts_pkg::MONTH_MIN) begin
                                w_raw.month = r_time.month - 4'd1;
                            end
                        end
                        dts_pkg::FLD_YEAR: begin
                            if (w_up) begin
                                if (r_time.year != dts_pkg::YEAR_MAX) begin
                                    w_raw.year = r_time.year + 12'd1;
                                end
                            end else if (r_time.year != dts_pkg::YEAR_MIN) begin
                                w_raw.year = r_time.year - 12'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dts_pkg::REQ_LOAD: begin
                // load works in any mode, edit flag and cursor untouched
                w_raw = r_load;
            end
            default: begin
                // tick and unused code: no change
            end
        endcase
    end

    dts_clamp u_clamp (
        .i_raw  (w_raw),
        .o_time (n_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= dts_pkg::TIME_RST;
            r_edit   <= 1'b0;
            r_cursor <= dts_pkg::FLD_HOUR;
        end else if (w_move) begin
            r_time   <= n_time;
            r_edit   <= n_edit;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_time   <= n_time;
            r_out_edit   <= n_edit;
            r_out_cursor <= n_cursor;
            r_out_commit <= n_commit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hour_out   = r_out_time.hour;
    assign o_minute_out = r_out_time.minute;
    assign o_second_out = r_out_time.second;
    assign o_day_out    = r_out_time.day;
    assign o_month_out  = r_out_time.month;
    assign o_year_out   = r_out_time.year;
    assign o_editing    = r_out_edit;
    assign o_cursor     = r_out_cursor;
    assign o_commit     = r_out_commit;

    // ---- assertions ----
    `DTS_ASSERT_NORST(a_rst_no_result, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")
    `DTS_ASSERT(a_commit_exits, i_clk, i_rst_n, o_valid && o_commit |-> !o_editing, "commit while editing")
    `DTS_ASSERT(a_year_range, i_clk, i_rst_n, o_valid |-> (o_year_out >= dts_pkg::YEAR_MIN) && (o_year_out <= dts_pkg::YEAR_MAX), "year out of range")
    `DTS_ASSERT(a_day_range, i_clk, i_rst_n, o_valid |-> (o_day_out != 5'd0) && (o_day_out <= dts_pkg::month_len(o_month_out, o_year_out)), "day beyond month length")
    `DTS_ASSERT(a_cursor_step, i_clk, i_rst_n, w_move |=> (r_cursor == $past(r_cursor)) || (r_cursor == $past(r_cursor) + 3'd1) || (r_cursor + 3'd1 == $past(r_cursor)), "cursor jumped")

endmodule

/* verif/date_time_setter_tb.sv */
// Self-checking testbench for the date/time setter: directed and random event words.
`timescale 1ns / 1ps

// One result word as the block shows it.
typedef struct packed {
    dts_pkg::t_time tm;
    logic           editing;
    logic [2:0]     cursor;
    logic           commit;
} t_shown;

// Tracks the edited time, predicts each result word and checks what comes out.
class setter_scoreboard;
    dts_pkg::t_time  now_t;
    logic            editing;
    dts_pkg::t_field cursor;
    t_shown          expected_words[$];
    int              errors;
    int              n_checked;

    function new();
        now_t     = dts_pkg::TIME_RST;
        editing   = 1'b0;
        cursor    = dts_pkg::FLD_HOUR;
        errors    = 0;
        n_checked = 0;
    endfunction

    static function int limit(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    static function int days_in(int m, int y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Year first, then month, then day against the month length.
    static function dts_pkg::t_time fit_time(int y, int mo, int d, int h, int mi, int s);
        dts_pkg::t_time t;
        y = limit(y, int'(dts_pkg::YEAR_MIN), int'(dts_pkg::YEAR_MAX));
        mo = limit(mo, int'(dts_pkg::MONTH_MIN), int'(dts_pkg::MONTH_MAX));
        d = limit(d, int'(dts_pkg::DAY_MIN), days_in(mo, y));
        t.year   = 12'(y);
        t.month  = 4'(mo);
        t.day    = 5'(d);
        t.hour   = 5'(limit(h, 0, int'(dts_pkg::HOUR_MAX)));
        t.minute = 6'(limit(mi, 0, int'(dts_pkg::MIN_MAX)));
        t.second = 6'(limit(s, 0, int'(dts_pkg::MIN_MAX)));
        return t;
    endfunction

    // Applies one accepted event word and queues the word it should give.
    function void note_event(logic [2:0] req, dts_pkg::t_time ld);
        int     f[6];
        t_shown w;
        w.commit = 1'b0;
        case (req)
            dts_pkg::REQ_LEFT, dts_pkg::REQ_RIGHT: begin
                if (!editing) begin
                    editing = 1'b1;
                end else if (req == dts_pkg::REQ_LEFT) begin
                    if (cursor != dts_pkg::FLD_HOUR)
                        cursor = dts_pkg::t_field'(cursor - 3'd1);
                end else if (cursor != dts_pkg::FLD_YEAR) begin
                    cursor = dts_pkg::t_field'(cursor + 3'd1);
                end
            end
            dts_pkg::REQ_CENTER: begin
                if (editing) begin
                    w.commit = 1'b1;
                    editing  = 1'b0;
                end
            end
            dts_pkg::REQ_UP, dts_pkg::REQ_DOWN: begin
                if (editing) begin
                    f[0] = now_t.hour;
                    f[1] = now_t.minute;
                    f[2] = now_t.second;
                    f[3] = now_t.day;
                    f[4] = now_t.month;
                    f[5] = now_t.year;
                    f[int'(cursor)] += (req == dts_pkg::REQ_UP) ? 1 : -1;
                    now_t = fit_time(f[5], f[4], f[3], f[0], f[1], f[2]);
                end
            end
            dts_pkg::REQ_LOAD: now_t = fit_time(ld.year, ld.month, ld.day, ld.hour,
                                                ld.minute, ld.second);
            default: begin
            end
        endcase
        w.tm      = now_t;
        w.editing = editing;
        w.cursor  = cursor;
        expected_words.insert(expected_words.size(), w);
    endfunction

    task report(string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    task cmp_field(string name, int got, int want);
        if (got != want)
            report($sformatf("word %0d: %s is %0d, expected %0d", n_checked, name, got, want));
    endtask

    task check_display(t_shown got);
        t_shown want;
        if (expected_words.size() == 0) begin
            report($sformatf("result word %0d with nothing expected", n_checked));
        end else begin
            want = expected_words.pop_front();
            cmp_field("hour",    got.tm.hour,   want.tm.hour);
            cmp_field("minute",  got.tm.minute, want.tm.minute);
            cmp_field("second",  got.tm.second, want.tm.second);
            cmp_field("day",     got.tm.day,    want.tm.day);
            cmp_field("month",   got.tm.month,  want.tm.month);
            cmp_field("year",    got.tm.year,   want.tm.year);
            cmp_field("editing", got.editing,   want.editing);
            cmp_field("cursor",  got.cursor,    want.cursor);
            cmp_field("commit",  got.commit,    want.commit);
        end
        n_checked++;
    endtask

    task check_drained();
        if (expected_words.size() != 0)
            report($sformatf("%0d expected words never came out", expected_words.size()));
    endtask
endclass

module date_time_setter_tb;

    // Unused request code: the block must treat it as a no-op.
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Pipeline is two deep; a few extra cycles catch stray result words.
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_req_type = dts_pkg::REQ_TICK;
    logic [11:0] i_load_year = '0;
    logic [3:0]  i_load_month = '0;
    logic [4:0]  i_load_day = '0;
    logic [4:0]  i_load_hour = '0;
    logic [5:0]  i_load_minute = '0;
    logic [5:0]  i_load_second = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [11:0] o_year_out;
    logic        o_editing;
    logic [2:0]  o_cursor;
    logic        o_commit;

    setter_scoreboard sb;
    int src_idle_pct = 0;   // chance per cycle that the sender holds off
    int dst_idle_pct = 0;   // chance per cycle that the receiver stalls
    int n_sent = 0;         // event words taken by the block
    int quiet_cycles = 0;

    date_time_setter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_load_year   (i_load_year),
        .i_load_month  (i_load_month),
        .i_load_day    (i_load_day),
        .i_load_hour   (i_load_hour),
        .i_load_minute (i_load_minute),
        .i_load_second (i_load_second),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hour_out    (o_hour_out),
        .o_minute_out  (o_minute_out),
        .o_second_out  (o_second_out),
        .o_day_out     (o_day_out),
        .o_month_out   (o_month_out),
        .o_year_out    (o_year_out),
        .o_editing     (o_editing),
        .o_cursor      (o_cursor),
        .o_commit      (o_commit)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side back-pressure, redrawn every falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end

    // Result checking and hang watchdog, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_shown got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.tm.hour   = o_hour_out;
                got.tm.minute = o_minute_out;
                got.tm.second = o_second_out;
                got.tm.day    = o_day_out;
                got.tm.month  = o_month_out;
                got.tm.year   = o_year_out;
                got.editing   = o_editing;
                got.cursor    = o_cursor;
                got.commit    = o_commit;
                sb.check_display(got);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic dts_pkg::t_time make_time(int y, int mo, int d, int h, int mi, int s);
        dts_pkg::t_time t;
        t.year   = 12'(y);
        t.month  = 4'(mo);
        t.day    = 5'(d);
        t.hour   = 5'(h);
        t.minute = 6'(mi);
        t.second = 6'(s);
        return t;
    endfunction

    // Half plain random bits, half values packed around the clamp edges.
    function automatic dts_pkg::t_time random_load();
        dts_pkg::t_time t;
        if ($urandom_range(0, 1)) begin
            t = make_time($urandom_range(0, 4095), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            case ($urandom_range(0, 2))
                0:       t.year = 12'($urandom_range(1895, 1905));
                1:       t.year = 12'($urandom_range(2095, 2105));
                default: t.year = 12'($urandom_range(1995, 2030));
            endcase
            t.month  = ($urandom_range(0, 2) == 0) ? 4'd2 : 4'($urandom_range(0, 13));
            t.day    = 5'($urandom_range(26, 31));
            t.hour   = $urandom_range(0, 1) ? 5'($urandom_range(21, 25)) : 5'd0;
            t.minute = $urandom_range(0, 1) ? 6'($urandom_range(57, 63)) : 6'd0;
            t.second = $urandom_range(0, 1) ? 6'($urandom_range(57, 63)) : 6'd0;
        end
        return t;
    endfunction

    // Called at a falling edge, returns at a falling edge after the word is taken.
    task automatic send_word(input logic [2:0] req, input dts_pkg::t_time ld);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            // sender gap: payload is junk while valid is low
            i_valid    <= 1'b0;
            i_req_type <= 3'($urandom);
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_load_year   <= ld.year;
        i_load_month  <= ld.month;
        i_load_day    <= ld.day;
        i_load_hour   <= ld.hour;
        i_load_minute <= ld.minute;
        i_load_second <= ld.second;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_event(req, ld);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Corner cases: ignored events, load clamping, cursor and field saturation,
    // day re-clamp on year and month change, load while editing, commit.
    task automatic run_directed();
        send_word(dts_pkg::REQ_UP, random_load());       // turn outside editing
        send_word(dts_pkg::REQ_CENTER, random_load());   // center outside editing
        send_word(dts_pkg::REQ_TICK, random_load());
        send_word(REQ_UNUSED, random_load());
        send_word(dts_pkg::REQ_LOAD, make_time(4095, 15, 31, 31, 63, 63));
        send_word(dts_pkg::REQ_LOAD, make_time(0, 0, 0, 0, 0, 0));
        send_word(dts_pkg::REQ_LOAD, make_time(2000, 2, 31, 12, 30, 45));  // leap by 400
        send_word(dts_pkg::REQ_LOAD, make_time(1900, 2, 29, 1, 2, 3));     // century, no leap
        send_word(dts_pkg::REQ_LOAD, make_time(2100, 2, 29, 23, 59, 59));
        send_word(dts_pkg::REQ_LOAD, make_time(2024, 2, 30, 0, 0, 0));
        send_word(dts_pkg::REQ_RIGHT, random_load());    // first click only enters editing
        send_word(dts_pkg::REQ_LEFT, random_load());     // cursor already at hour
        send_word(dts_pkg::REQ_DOWN, random_load());     // hour 0 stays 0
        send_word(dts_pkg::REQ_UP, random_load());
        repeat (6) send_word(dts_pkg::REQ_RIGHT, random_load());  // last one saturates
        send_word(dts_pkg::REQ_UP, random_load());       // 2025: Feb 29 -> 28
        send_word(dts_pkg::REQ_LEFT, random_load());     // to month
        send_word(dts_pkg::REQ_UP, random_load());
        send_word(dts_pkg::REQ_LOAD, make_time(2100, 12, 31, 23, 59, 59));
        send_word(dts_pkg::REQ_RIGHT, random_load());
        send_word(dts_pkg::REQ_UP, random_load());       // year 2100 holds
        send_word(dts_pkg::REQ_CENTER, random_load());   // commit, cursor kept
        send_word(dts_pkg::REQ_LEFT, random_load());     // re-enter editing
    endtask

    // Mostly clicks and bursts of turns inside editing; loads, commits and
    // no-ops mixed in. Runs until about n_words words have been sent.
    task automatic run_random(input int n_words);
        int first;
        int pick;
        logic [2:0] dir;
        first = n_sent;
        while (n_sent - first < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                send_word(dts_pkg::REQ_LEFT, random_load());
            end else if (pick < 28) begin
                send_word(dts_pkg::REQ_RIGHT, random_load());
            end else if (pick < 62) begin
                dir = $urandom_range(0, 1) ? dts_pkg::REQ_UP : dts_pkg::REQ_DOWN;
                repeat ($urandom_range(1, 6)) send_word(dir, random_load());
            end else if (pick < 68) begin
                send_word(dts_pkg::REQ_CENTER, random_load());
            end else if (pick < 72) begin
                send_word(dts_pkg::REQ_TICK, random_load());
            end else if (pick < 74) begin
                send_word(REQ_UNUSED, random_load());
            end else begin
                send_word(dts_pkg::REQ_LOAD, random_load());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase 1: both sides idle, sender less often
        src_idle_pct = 35;
        dst_idle_pct = 49;
        run_directed();
        run_random(140);
        // phase 2: swapped idle rates
        src_idle_pct = 49;
        dst_idle_pct = 35;
        run_random(140);
        // phase 3: back to back, no idling
        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random(140);
        i_valid <= 1'b0;

        // drain; the watchdog covers a block that stops answering
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
